>>> src/mutex_lock_manager_defines.svh
// ---------------------------------------------------------------------------
// Mutex lock manager assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MUTEX_LOCK_MANAGER_DEFINES_SVH
`define MUTEX_LOCK_MANAGER_DEFINES_SVH

`ifndef SYNTH
// Checked only while out of reset.
`define MLM_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define MLM_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLM_ASSERT(name, clk, rst_n, prop, msg)
`define MLM_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> src/mlm_pkg.sv
// ---------------------------------------------------------------------------
// Mutex lock manager package
// Action and status codes, controller/datapath command and status bundles.
// ---------------------------------------------------------------------------
package mlm_pkg;

    // Table geometry, fixed by the 4-bit slot and thread fields
    localparam int SLOT_COUNT   = 16;
    localparam int THREAD_COUNT = 16;

    // Request actions (codes above ACT_UNLOCK are rejected)
    localparam logic [2:0] ACT_CREATE  = 3'd0;
    localparam logic [2:0] ACT_DESTROY = 3'd1;
    localparam logic [2:0] ACT_LOCK    = 3'd2;
    localparam logic [2:0] ACT_TRYLOCK = 3'd3;
    localparam logic [2:0] ACT_UNLOCK  = 3'd4;

    // Mutex kinds
    localparam logic [1:0] KIND_RECURSIVE = 2'd1;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_BUSY       = 3'd2;
    localparam logic [2:0] ST_DEADLOCK   = 3'd3;
    localparam logic [2:0] ST_NOT_OWNER  = 3'd4;
    localparam logic [2:0] ST_QUEUED     = 3'd5;
    localparam logic [2:0] ST_NO_SLOT    = 3'd6;
    localparam logic [2:0] ST_COUNT_FULL = 3'd7;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // capture request, read slot record, find free slot
        logic exec;      // decide, write back record and waiter queue
        logic load_out;  // load output register
        logic out_live;  // load from this cycle's decision, else from held result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic wake;      // decision pops a waiter, queue read in flight
    } t_stat;

endpackage

>>> src/mlm_ctrl.sv
// ---------------------------------------------------------------------------
// Mutex lock manager controller
// Sequences request capture, execute, waiter read and result hand-off.
// ---------------------------------------------------------------------------
`include "mutex_lock_manager_defines.svh"

module mlm_ctrl
    import mlm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POP  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.wake) begin
                    n_state = S_POP;
                end else if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_live = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_POP, S_WAIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.load_out ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `MLM_ASSERT(a_accept_to_exec, i_clk, i_rst_n, i_in_valid && o_in_ready |=> r_state == S_EXEC, "accepted beat did not enter execute")
    `MLM_ASSERT(a_pop_after_wake, i_clk, i_rst_n, r_state == S_POP |-> $past(r_state) == S_EXEC && $past(i_stat.wake), "waiter read without a wake decision")
    `MLM_ASSERT(a_load_when_free, i_clk, i_rst_n, o_cmd.load_out |-> !r_out_valid || i_out_ready, "output overwritten before taken")
    `MLM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> r_state == S_IDLE && !r_out_valid, "controller not idle after reset")

endmodule

>>> src/mlm_datapath.sv
// ---------------------------------------------------------------------------
// Mutex lock manager datapath
// Slot record memory, waiter queue memory, lock decision and result registers.
// ---------------------------------------------------------------------------
`include "mutex_lock_manager_defines.svh"

module mlm_datapath
    import mlm_pkg::*;
#(
    parameter int COUNT_BITS   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic [2:0] i_action,
    input  logic [3:0] i_slot,
    input  logic [3:0] i_thread_id,
    input  logic [1:0] i_mutex_kind,
    output logic [2:0] o_status,
    output logic [3:0] o_slot_out,
    output logic       o_wake_valid,
    output logic [3:0] o_wake_thread
);

    localparam int SB = $clog2(SLOT_COUNT);
    localparam int TB = $clog2(THREAD_COUNT);
    localparam int AW = $clog2(SLOT_COUNT * THREAD_COUNT);

    typedef struct packed {
        logic                  recursive;
        logic                  held;
        logic [TB-1:0]         owner;
        logic [COUNT_BITS-1:0] count;
        logic [TB-1:0]         head;
        logic [TB:0]           total;
    } t_rec;

    // storage
    t_rec          rec_mem [SLOT_COUNT];
    logic [TB-1:0] wq_mem  [SLOT_COUNT * THREAD_COUNT];
    logic [SLOT_COUNT-1:0] r_used;

    // captured request
    logic [2:0]    r_action;
    logic [3:0]    r_slot;
    logic [3:0]    r_tid;
    logic [1:0]    r_kind;
    t_rec          r_rec;
    logic          r_free_found;
    logic [SB-1:0] r_free_idx;

    // held result
    logic [2:0]    r_res_status;
    logic [3:0]    r_res_slot;
    logic          r_res_wake;
    logic [TB-1:0] r_wake_tid;

    // decision
    logic                  free_found;
    logic [SB-1:0]         free_idx;
    logic [SB-1:0]         sidx;
    logic [TB-1:0]         tid_t;
    logic                  slot_ok, tid_ok;
    logic [2:0]            n_status;
    logic [3:0]            n_slot_o;
    logic                  wake, push, rec_we, used_set, used_clr;
    t_rec                  n_rec;
    logic [SB-1:0]         rec_widx;
    logic [TB:0]           push_sum;
    logic [TB-1:0]         push_pos, head_inc, qpos;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic [AW-1:0]         q_addr;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = SB'(i);
            end
        end
    end

    assign sidx    = SB'(r_slot);
    assign tid_t   = TB'(r_tid);
    assign slot_ok = 32'(r_slot) < SLOT_COUNT;
    assign tid_ok  = 32'(r_tid) < THREAD_COUNT;

    assign push_sum = {1'b0, r_rec.head} + r_rec.total;
    assign push_pos = (push_sum >= (TB+1)'(THREAD_COUNT))
                    ? TB'(push_sum - (TB+1)'(THREAD_COUNT)) : TB'(push_sum);
    assign head_inc = (r_rec.head == TB'(THREAD_COUNT - 1)) ? '0 : r_rec.head + TB'(1);
    assign cnt_dec  = (r_rec.count != '0) ? r_rec.count - COUNT_BITS'(1) : r_rec.count;
    assign qpos     = push ? push_pos : r_rec.head;
    assign q_addr   = AW'(32'(sidx) * THREAD_COUNT) + AW'(qpos);

    always_comb begin
        n_status = ST_INVALID;
        n_slot_o = r_slot;
        wake     = 1'b0;
        push     = 1'b0;
        rec_we   = 1'b0;
        used_set = 1'b0;
        used_clr = 1'b0;
        n_rec    = r_rec;
        rec_widx = sidx;
        priority if (r_action > ACT_UNLOCK || !tid_ok) begin
            n_status = ST_INVALID;
        end else if (r_action == ACT_CREATE) begin
            if (r_kind > KIND_RECURSIVE) begin
                n_status = ST_INVALID;
            end else if (!r_free_found) begin
                n_status = ST_NO_SLOT;
            end else begin
                n_rec           = '0;
                n_rec.recursive = r_kind[0];
                rec_widx        = r_free_idx;
                rec_we          = 1'b1;
                used_set        = 1'b1;
                n_slot_o        = 4'(r_free_idx);
                n_status        = ST_OK;
            end
        end else if (!slot_ok || !r_used[sidx]) begin
            n_status = ST_INVALID;
        end else begin
            unique case (r_action)
                ACT_DESTROY: begin
                    if (r_rec.held || r_rec.total != '0) begin
                        n_status = ST_BUSY;
                    end else begin
                        used_clr = 1'b1;
                        n_status = ST_OK;
                    end
                end
                ACT_LOCK, ACT_TRYLOCK: begin
                    if (!r_rec.held) begin
                        n_rec.held  = 1'b1;
                        n_rec.owner = tid_t;
                        n_rec.count = COUNT_BITS'(1);
                        rec_we      = 1'b1;
                        n_status    = ST_OK;
                    end else if (r_rec.owner == tid_t && r_rec.recursive) begin
                        if (r_rec.count == '1) begin
                            n_status = ST_COUNT_FULL;
                        end else begin
                            n_rec.count = r_rec.count + COUNT_BITS'(1);
                            rec_we      = 1'b1;
                            n_status    = ST_OK;
                        end
                    end else if (r_action == ACT_TRYLOCK) begin
                        n_status = ST_BUSY;
                    end else if (r_rec.owner == tid_t) begin
                        n_status = ST_DEADLOCK;
                    end else if (r_rec.total == (TB+1)'(THREAD_COUNT)) begin
                        n_status = ST_BUSY;
                    end else begin
                        push        = 1'b1;
                        n_rec.total = r_rec.total + (TB+1)'(1);
                        rec_we      = 1'b1;
                        n_status    = ST_QUEUED;
                    end
                end
                default: begin
                    if (!r_rec.held || r_rec.owner != tid_t) begin
                        n_status = ST_NOT_OWNER;
                    end else begin
                        n_status    = ST_OK;
                        rec_we      = 1'b1;
                        n_rec.count = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_rec.held  = 1'b0;
                            n_rec.owner = '0;
                            if (r_rec.total != '0) begin
                                wake        = 1'b1;
                                n_rec.head  = head_inc;
                                n_rec.total = r_rec.total - (TB+1)'(1);
                            end
                        end
                    end
                end
            endcase
        end
    end

    assign o_stat.wake     = wake;

    // slot-used bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.exec) begin
            if (used_set) r_used[r_free_idx] <= 1'b1;
            if (used_clr) r_used[sidx]       <= 1'b0;
        end
    end

    // request capture, memories, result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action     <= i_action;
            r_slot       <= i_slot;
            r_tid        <= i_thread_id;
            r_kind       <= i_mutex_kind;
            r_rec        <= rec_mem[SB'(i_slot)];
            r_free_found <= free_found;
            r_free_idx   <= free_idx;
        end
        if (i_cmd.exec) begin
            if (rec_we) rec_mem[rec_widx] <= n_rec;
            if (push)   wq_mem[q_addr]    <= tid_t;
            if (wake)   r_wake_tid        <= wq_mem[q_addr];
            r_res_status <= n_status;
            r_res_slot   <= n_slot_o;
            r_res_wake   <= wake;
        end
        if (i_cmd.load_out) begin
            if (i_cmd.out_live) begin
                o_status      <= n_status;
                o_slot_out    <= n_slot_o;
                o_wake_valid  <= 1'b0;
                o_wake_thread <= '0;
            end else begin
                o_status      <= r_res_status;
                o_slot_out    <= r_res_slot;
                o_wake_valid  <= r_res_wake;
                o_wake_thread <= r_res_wake ? 4'(r_wake_tid) : 4'd0;
            end
        end
    end

    `MLM_ASSERT(a_push_pop_excl, i_clk, i_rst_n, i_cmd.exec |-> !(push && wake), "queue push and pop in one request")
    `MLM_ASSERT(a_wake_is_ok, i_clk, i_rst_n, i_cmd.load_out && !i_cmd.out_live && r_res_wake |=> o_wake_valid && o_status == ST_OK, "wake reported without a successful unlock")

endmodule

>>> src/mutex_lock_manager.sv
// A request is captured, then executed, and its result goes to the output register;
//   an unlock that wakes a waiter first does a registered waiter queue read.
// Requests are handled one at a time, each a read-modify-write of one slot record.
// A new request is taken while the previous result still waits on the output.
// Reset (synchronous, active low) clears the slot-used bits and the controller;
//   the record and waiter memories are not cleared, so no clearing pass is run.
// ---------------------------------------------------------------------------
// Mutex lock manager
// Lock table of mutex slots with owner, hold count and per-slot waiter FIFO.
// ---------------------------------------------------------------------------
module mutex_lock_manager
    import mlm_pkg::*;
#(
    parameter int COUNT_BITS   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_action,
    input  logic [3:0] i_slot,
    input  logic [3:0] i_thread_id,
    input  logic [1:0] i_mutex_kind,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic [3:0] o_slot_out,
    output logic       o_wake_valid,
    output logic [3:0] o_wake_thread
);

    // Controller steps the request through capture, execute, optional waiter
    // read and output hand-off; the datapath holds all table state.
    t_cmd  cmd;
    t_stat stat;

    mlm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Decide on the captured request, write back the slot record, push or
    // pop the waiter FIFO, and hold the result beat until it is taken.
    mlm_datapath #(
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_slot        (i_slot),
        .i_thread_id   (i_thread_id),
        .i_mutex_kind  (i_mutex_kind),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_wake_valid  (o_wake_valid),
        .o_wake_thread (o_wake_thread)
    );

endmodule
